// ===== design/ffx_pkg.sv =====
// ----------------------------------------------------------------------------
// ffx_pkg
// Shared types and constants of the form field extract and decode core.
// ----------------------------------------------------------------------------
package ffx_pkg;

  localparam int unsigned MaxKeyChars = 30;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned KeyWords    = 4;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChEquals  = 8'h3D;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_LENGTH = 3'd0,
    CFG_KEY_LOW    = 3'd1,
    CFG_KEY_MID    = 3'd2,
    CFG_KEY_HIGH   = 3'd3,
    CFG_KEY_TOP    = 3'd4,
    CFG_MAX_VALUE  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_MATCH = 2'd0,
    PH_SKIP  = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       end_of_body;
    logic       key_found;
    logic [7:0] value_length;
  } out_item_t;

  // All results caused by one input byte: up to three decoded bytes and an
  // optional end marker.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      data_cnt;
    logic            has_end;
    logic            found;
    logic [7:0]      length;
  } bundle_t;

endpackage

// ===== design/ffx_front.sv =====
// ----------------------------------------------------------------------------
// ffx_front
// Parser: holds the configuration, matches the key and percent-decodes the
// value, producing at most one result bundle per input byte.
// ----------------------------------------------------------------------------
module ffx_front import ffx_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                accept_i,
  input  in_item_t            item_i,
  output logic                bundle_push_o,
  output bundle_t             bundle_o
);

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  // Configuration registers.
  logic [4:0]                       klen_q;
  logic [KeyWords-1:0][CfgDataW-1:0] key_q;
  logic [7:0]                       maxb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= 5'd1;
      key_q  <= '0;
      maxb_q <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_KEY_LENGTH: begin
          klen_q <= (cfg_wdata_i[4:0] > 5'(MaxKeyChars)) ? 5'(MaxKeyChars)
                                                         : cfg_wdata_i[4:0];
        end
        CFG_KEY_LOW:   key_q[0] <= cfg_wdata_i;
        CFG_KEY_MID:   key_q[1] <= cfg_wdata_i;
        CFG_KEY_HIGH:  key_q[2] <= cfg_wdata_i;
        CFG_KEY_TOP:   key_q[3] <= cfg_wdata_i;
        CFG_MAX_VALUE: maxb_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Parse state.
  phase_e     phase_q, phase_d;
  logic [4:0] mpos_q, mpos_d;
  logic [1:0] pc_q, pc_d;
  logic [7:0] phb_q, phb_d;
  logic [7:0] ec_q, ec_d;
  logic       found_q, found_d;

  logic [KeyWords*CfgDataW-1:0] key_flat;
  assign key_flat = key_q;

  always_comb begin
    logic [7:0]      b;
    logic [7:0]      expect_ch;
    logic [2:0][7:0] cand;
    logic [1:0]      cnt;
    logic            consumed;
    logic [7:0]      avail;
    logic [1:0]      nem;

    b         = item_i.body_byte;
    phase_d   = phase_q;
    mpos_d    = mpos_q;
    pc_d      = pc_q;
    phb_d     = phb_q;
    found_d   = found_q;
    cand      = '0;
    cnt       = 2'd0;
    consumed  = 1'b0;
    expect_ch = (mpos_q < klen_q) ? key_flat[{mpos_q, 3'b000} +: 8] : ChEquals;

    unique case (phase_q)
      PH_MATCH: begin
        if (b != ChAmp && b == expect_ch) begin
          if (mpos_q >= klen_q) begin
            phase_d = PH_VALUE;
            found_d = 1'b1;
            mpos_d  = 5'd0;
          end else begin
            mpos_d = mpos_q + 5'd1;
          end
        end else begin
          mpos_d  = 5'd0;
          phase_d = (b == ChAmp) ? PH_MATCH : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == ChAmp) begin
          phase_d = PH_MATCH;
          mpos_d  = 5'd0;
        end
      end
      PH_VALUE: begin
        if (b == ChAmp) begin
          // A held percent sequence is released raw at the end of the value.
          if (pc_d != 2'd0) begin
            cand[cnt] = ChPercent;
            cnt       = cnt + 2'd1;
          end
          if (pc_d == 2'd2) begin
            cand[cnt] = phb_d;
            cnt       = cnt + 2'd1;
          end
          pc_d    = 2'd0;
          phb_d   = 8'd0;
          phase_d = PH_DONE;
        end else begin
          if (pc_d != 2'd0) begin
            if (is_hex(b)) begin
              consumed = 1'b1;
              if (pc_d == 2'd1) begin
                phb_d = b;
                pc_d  = 2'd2;
              end else begin
                cand[cnt] = {hex_val(phb_d), hex_val(b)};
                cnt       = cnt + 2'd1;
                pc_d      = 2'd0;
                phb_d     = 8'd0;
              end
            end else begin
              cand[cnt] = ChPercent;
              cnt       = cnt + 2'd1;
              if (pc_d == 2'd2) begin
                cand[cnt] = phb_d;
                cnt       = cnt + 2'd1;
              end
              pc_d  = 2'd0;
              phb_d = 8'd0;
            end
          end
          if (!consumed) begin
            if (b == ChPercent) begin
              pc_d = 2'd1;
            end else if (b == ChPlus) begin
              cand[cnt] = ChSpace;
              cnt       = cnt + 2'd1;
            end else begin
              cand[cnt] = b;
              cnt       = cnt + 2'd1;
            end
          end
        end
      end
      default: ;
    endcase

    if (item_i.last_byte && phase_d == PH_VALUE) begin
      if (pc_d != 2'd0) begin
        cand[cnt] = ChPercent;
        cnt       = cnt + 2'd1;
      end
      if (pc_d == 2'd2) begin
        cand[cnt] = phb_d;
        cnt       = cnt + 2'd1;
      end
    end

    // The length limit keeps a prefix of the candidate bytes. A limit lowered
    // below the count already emitted leaves no room at all.
    avail = (ec_q < maxb_q) ? maxb_q - ec_q : 8'd0;
    nem   = ({6'd0, cnt} > avail) ? avail[1:0] : cnt;
    ec_d  = ec_q + {6'd0, nem};

    bundle_o.data     = cand;
    bundle_o.data_cnt = nem;
    bundle_o.has_end  = item_i.last_byte;
    bundle_o.found    = found_d;
    bundle_o.length   = ec_d;
    bundle_push_o     = accept_i && (nem != 2'd0 || item_i.last_byte);

    if (item_i.last_byte) begin
      phase_d = PH_MATCH;
      mpos_d  = 5'd0;
      pc_d    = 2'd0;
      phb_d   = 8'd0;
      ec_d    = 8'd0;
      found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MATCH;
      mpos_q  <= 5'd0;
      pc_q    <= 2'd0;
      phb_q   <= 8'd0;
      ec_q    <= 8'd0;
      found_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      mpos_q  <= mpos_d;
      pc_q    <= pc_d;
      phb_q   <= phb_d;
      ec_q    <= ec_d;
      found_q <= found_d;
    end
  end

endmodule

// ===== design/ffx_queue.sv =====
// ----------------------------------------------------------------------------
// ffx_queue
// Small first-in first-out buffer of result bundles between parser and
// result serializer.
// ----------------------------------------------------------------------------
module ffx_queue import ffx_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  bundle_t wdata_i,
  input  logic    rd_i,
  output bundle_t rdata_o,
  output logic    full_o,
  output logic    empty_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  bundle_t            slots_q [Depth];
  logic [AddrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slots_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (rd_i) begin
        rptr_q <= (rptr_q == AddrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/ffx_back.sv =====
// ----------------------------------------------------------------------------
// ffx_back
// Result serializer: holds one bundle and hands out its results one per
// transaction.
// ----------------------------------------------------------------------------
module ffx_back import ffx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bundle_t   q_data_i,
  input  logic      q_empty_i,
  output logic      q_rd_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  bundle_t    cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;

  logic [2:0] total;
  logic       at_last;
  logic       load;

  assign total   = {1'b0, cur_q.data_cnt} + {2'b00, cur_q.has_end};
  assign at_last = ({1'b0, idx_q} == total - 3'd1);
  assign load    = !cur_valid_q || (pop_i && at_last);
  assign q_rd_o  = load && !q_empty_i;
  assign empty_o = !cur_valid_q;

  always_comb begin
    if (idx_q < cur_q.data_cnt) begin
      out_item_o.value_byte   = cur_q.data[idx_q];
      out_item_o.byte_valid   = 1'b1;
      out_item_o.end_of_body  = 1'b0;
      out_item_o.key_found    = 1'b0;
      out_item_o.value_length = 8'd0;
    end else begin
      out_item_o.value_byte   = 8'd0;
      out_item_o.byte_valid   = 1'b0;
      out_item_o.end_of_body  = 1'b1;
      out_item_o.key_found    = cur_q.found;
      out_item_o.value_length = cur_q.length;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      cur_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (load) begin
      cur_valid_q <= !q_empty_i;
      idx_q       <= 2'd0;
    end else if (pop_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// ===== design/form_field_extract_decode_core.sv =====
// ----------------------------------------------------------------------------
// form_field_extract_decode_core
// Extracts one field from an url-encoded form body and percent-decodes its
// value, one body byte per transaction in and one result per transaction out.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload            Direction
//   -------  -------------------  -----------------  ---------
//   input    push / full          in_item_i          in
//   result   empty / pop          out_item_o         out
//   config   cfg_we_i             cfg_index_i/wdata  in
//
// A body byte is taken in every cycle in which push is high and full is low:
// the parser classifies it in the cycle of its transaction and writes its
// results, up to four, as one bundle into a queue of QUEUE_DEPTH bundles.
// The serializer hands out one result per cycle while pop is held, so the
// sustained input rate is one byte per cycle whenever results are taken as
// fast as they appear; a byte with several results needs one pop per result
// on the result side. The accepting edge writes a byte's bundle into the
// queue, from where it moves into the serializer once that one is free.
// full rises only when the queue holds QUEUE_DEPTH bundles. Reset is
// asynchronous; afterward the key length is 1, the key is all zero and the
// value limit is 255.
module form_field_extract_decode_core import ffx_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_item_o
);

  logic    accept;
  logic    bundle_push;
  bundle_t bundle_in;
  bundle_t bundle_out;
  logic    q_rd;
  logic    q_empty;

  // An item is taken whenever the queue has room for its bundle.
  assign accept = push && !full;

  ffx_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .item_i        (in_item_i),
    .bundle_push_o (bundle_push),
    .bundle_o      (bundle_in)
  );

  ffx_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (bundle_push),
    .wdata_i (bundle_in),
    .rd_i    (q_rd),
    .rdata_o (bundle_out),
    .full_o  (full),
    .empty_o (q_empty)
  );

  // The serializer keeps the oldest bundle in a register of its own, so the
  // queue and the parser keep running, until the queue fills, while a result waits to be taken.
  ffx_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_data_i   (bundle_out),
    .q_empty_i  (q_empty),
    .q_rd_o     (q_rd),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule
